>>> rtl/etsc_pkg.sv
`timescale 1ns / 1ps
package etsc_pkg;

  // fixed field widths
  localparam int unsigned ENERGY_W  = 58;
  localparam int unsigned BLEN_W    = 9;
  localparam int unsigned WLEN_W    = 11;
  localparam int unsigned AMP_W     = 8;
  localparam int unsigned STATE_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // register reset values
  localparam logic [BLEN_W-1:0]   BLEN_RST  = BLEN_W'(50);
  localparam logic [WLEN_W-1:0]   WLEN_RST  = WLEN_W'(500);
  localparam logic [ENERGY_W-1:0] UPPER_RST = ENERGY_W'(64'd140737488355);
  localparam logic [ENERGY_W-1:0] LOWER_RST = ENERGY_W'(64'd52776558133);
  localparam logic [AMP_W-1:0]    MAXA_RST  = AMP_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LEN = 3'd0,
    CFG_WINDOW_LEN = 3'd1,
    CFG_UPPER = 3'd2,
    CFG_LOWER = 3'd3,
    CFG_MAX_AMP = 3'd4
  } cfg_idx_t;

  typedef enum logic [STATE_W-1:0] {
    STIM_ABOVE = 2'd0,
    STIM_BETWEEN = 2'd1,
    STIM_BELOW = 2'd2
  } stim_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WR_RD,
    ST_WR_WR,
    ST_EN_START,
    ST_EN_RUN,
    ST_DECIDE
  } seq_state_t;

endpackage

>>> rtl/etsc_if.sv
`timescale 1ns / 1ps
interface etsc_in_if #(parameter int unsigned SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface etsc_out_if;
  logic                             valid;
  logic                             ready;
  logic [etsc_pkg::ENERGY_W-1:0]    energy;
  logic [etsc_pkg::STATE_W-1:0]     stim_state;
  logic [etsc_pkg::AMP_W-1:0]       amplitude;
  logic                             cmd_sent;
  modport source (output valid, output energy, output stim_state, output amplitude,
                  output cmd_sent, input ready);
  modport sink (input valid, input energy, input stim_state, input amplitude,
                input cmd_sent, output ready);
endinterface

interface etsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [etsc_pkg::CFG_IDX_W-1:0]   index;
  logic [etsc_pkg::ENERGY_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/energy_threshold_stim_controller.sv
`timescale 1ns / 1ps
// channel  | direction | payload
// in_ch    | in        | sample
// out_ch   | out       | energy, stim_state, amplitude, cmd_sent
// cfg_ch   | in        | index, data (always ready)
//
// a sample that does not end a block is stored and summed; a block end runs
// the serial divider for the mean, then the ring write (a block store read
// state and a ring write state per sample), then one ring read per window
// entry through the square-accumulate unit.
// the first DISCARD_BLOCKS block ends stop after the ring write.
// after reset a clearing pass zeroes all RING_DEPTH ring entries; no item
// is accepted meanwhile. a result waiting on out_ch holds the next block end.
module energy_threshold_stim_controller #(
  parameter int unsigned RING_DEPTH     = 1024,
  parameter int unsigned BLOCK_MAX      = 256,
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned DISCARD_BLOCKS = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  etsc_in_if.sink     in_ch,
  etsc_out_if.source  out_ch,
  etsc_cfg_if.sink    cfg_ch
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned FW    = $clog2(BLOCK_MAX + 1);
  localparam int unsigned AW    = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
  localparam int unsigned SUM_W = SW + $clog2(BLOCK_MAX) + 1;
  localparam int unsigned RW    = $clog2(RING_DEPTH);
  localparam int unsigned WW    = $clog2(RING_DEPTH + 1);
  localparam int unsigned EW    = etsc_pkg::ENERGY_W;
  localparam int unsigned AMW   = etsc_pkg::AMP_W;

  // config registers
  logic [etsc_pkg::BLEN_W-1:0] blen_cfg_r;
  logic [etsc_pkg::WLEN_W-1:0] wlen_cfg_r;
  logic [EW-1:0]               upper_r, lower_r;
  logic [AMW-1:0]              maxa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_cfg_r <= etsc_pkg::BLEN_RST;
      wlen_cfg_r <= etsc_pkg::WLEN_RST;
      upper_r    <= etsc_pkg::UPPER_RST;
      lower_r    <= etsc_pkg::LOWER_RST;
      maxa_r     <= etsc_pkg::MAXA_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        etsc_pkg::CFG_BLOCK_LEN:  blen_cfg_r <= cfg_ch.data[etsc_pkg::BLEN_W-1:0];
        etsc_pkg::CFG_WINDOW_LEN: wlen_cfg_r <= cfg_ch.data[etsc_pkg::WLEN_W-1:0];
        etsc_pkg::CFG_UPPER:      upper_r <= cfg_ch.data;
        etsc_pkg::CFG_LOWER:      lower_r <= cfg_ch.data;
        etsc_pkg::CFG_MAX_AMP:    maxa_r <= cfg_ch.data[AMW-1:0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  // effective block and window lengths
  logic [FW-1:0] blen;
  logic [WW-1:0] win;
  always_comb begin
    if (blen_cfg_r == '0) begin
      blen = FW'(1);
    end else if (32'(blen_cfg_r) > 32'(BLOCK_MAX)) begin
      blen = FW'(BLOCK_MAX);
    end else begin
      blen = FW'(blen_cfg_r);
    end
    if (32'(wlen_cfg_r) > 32'(RING_DEPTH)) begin
      win = WW'(RING_DEPTH);
    end else begin
      win = WW'(wlen_cfg_r);
    end
  end

  // sequencer state
  etsc_pkg::seq_state_t state_r, state_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] mean_r, mean_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic [FW-1:0]           n_r, n_nxt;
  logic [FW-1:0]           wi_r, wi_nxt;
  logic [RW-1:0]           wpos_r, wpos_nxt;
  logic [RW-1:0]           clr_r, clr_nxt;
  logic [RW-1:0]           ridx_r, ridx_nxt;
  logic [WW-1:0]           remain_r, remain_nxt;
  logic                    iss_v_r, iss_v_nxt;
  logic [2:0]              seen_r, seen_nxt;
  logic [AMW-1:0]          amp_r, amp_nxt;
  logic                    ov_r, ov_nxt;
  logic [EW-1:0]           oen_r, oen_nxt;
  logic [etsc_pkg::STATE_W-1:0] ost_r, ost_nxt;
  logic                    ocmd_r, ocmd_nxt;

  // memories and arithmetic units
  logic signed [SW-1:0] blk_mem [BLOCK_MAX];
  logic signed [SW-1:0] blk_q_r;
  logic signed [SW:0]   ring_mem [RING_DEPTH];
  logic signed [SW:0]   ring_q_r;
  logic                 blk_we;
  logic                 ring_we;
  logic [RW-1:0]        ring_waddr;
  logic signed [SW:0]   ring_wdata;

  logic                 div_start, div_busy;
  logic [SUM_W-1:0]     div_q;
  logic [SUM_W-1:0]     sum_mag;
  logic                 mac_clr, mac_busy;
  logic [EW-1:0]        mac_acc;

  logic                    in_acc;
  logic signed [SUM_W-1:0] s_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] diff;
  logic [RW+1:0]           start_idx;

  assign in_ch.ready = (state_r == etsc_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s_ext       = SUM_W'(in_ch.sample);
  assign b_ext       = SUM_W'(blk_q_r);
  assign diff        = b_ext - mean_r;
  assign sum_mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign start_idx   = (RW+2)'(wpos_r) + (RW+2)'(RING_DEPTH) - (RW+2)'(win);

  // block store: written on each accepted sample, read during the ring write
  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[fill_r[AW-1:0]] <= in_ch.sample;
    blk_q_r <= blk_mem[wi_r[AW-1:0]];
  end

  // ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_q_r <= ring_mem[ridx_r];
  end

  etsc_div #(.DW(SUM_W), .VW(FW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (n_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  etsc_mac #(.DW(SW + 1)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mac_clr),
    .in_v  (iss_v_r),
    .d     (ring_q_r),
    .busy  (mac_busy),
    .acc   (mac_acc)
  );

  // next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    mean_nxt   = mean_r;
    fill_nxt   = fill_r;
    n_nxt      = n_r;
    wi_nxt     = wi_r;
    wpos_nxt   = wpos_r;
    clr_nxt    = clr_r;
    ridx_nxt   = ridx_r;
    remain_nxt = remain_r;
    iss_v_nxt  = 1'b0;
    seen_nxt   = seen_r;
    amp_nxt    = amp_r;
    ov_nxt     = ov_r && !out_ch.ready;
    oen_nxt    = oen_r;
    ost_nxt    = ost_r;
    ocmd_nxt   = ocmd_r;
    blk_we     = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = wpos_r;
    ring_wdata = diff[SW:0];
    div_start  = 1'b0;
    mac_clr    = 1'b0;
    unique case (state_r)
      etsc_pkg::ST_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_r;
        ring_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (32'(clr_r) == RING_DEPTH - 1) state_nxt = etsc_pkg::ST_IDLE;
      end
      etsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          blk_we   = 1'b1;
          sum_nxt  = sum_r + s_ext;
          fill_nxt = fill_r + 1'b1;
          if (fill_r + 1'b1 >= blen) begin
            n_nxt     = fill_r + 1'b1;
            state_nxt = etsc_pkg::ST_DIV_START;
          end
        end
      end
      etsc_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = etsc_pkg::ST_DIV_WAIT;
      end
      etsc_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          mean_nxt  = sum_r[SUM_W-1] ? -$signed(div_q) : $signed(div_q);
          wi_nxt    = '0;
          state_nxt = etsc_pkg::ST_WR_RD;
        end
      end
      etsc_pkg::ST_WR_RD: begin
        state_nxt = etsc_pkg::ST_WR_WR;
      end
      etsc_pkg::ST_WR_WR: begin
        ring_we  = 1'b1;
        wpos_nxt = (32'(wpos_r) == RING_DEPTH - 1) ? '0 : wpos_r + 1'b1;
        wi_nxt   = wi_r + 1'b1;
        if (wi_r + 1'b1 == n_r) begin
          fill_nxt = '0;
          sum_nxt  = '0;
          if (32'(seen_r) < DISCARD_BLOCKS) begin
            seen_nxt  = seen_r + 1'b1;
            state_nxt = etsc_pkg::ST_IDLE;
          end else begin
            state_nxt = etsc_pkg::ST_EN_START;
          end
        end else begin
          state_nxt = etsc_pkg::ST_WR_RD;
        end
      end
      etsc_pkg::ST_EN_START: begin
        mac_clr    = 1'b1;
        remain_nxt = win;
        if (32'(start_idx) >= RING_DEPTH) begin
          ridx_nxt = RW'(start_idx - (RW+2)'(RING_DEPTH));
        end else begin
          ridx_nxt = RW'(start_idx);
        end
        state_nxt = etsc_pkg::ST_EN_RUN;
      end
      etsc_pkg::ST_EN_RUN: begin
        if (remain_r != '0) begin
          iss_v_nxt  = 1'b1;
          remain_nxt = remain_r - 1'b1;
          ridx_nxt   = (32'(ridx_r) == RING_DEPTH - 1) ? '0 : ridx_r + 1'b1;
        end else if (!iss_v_r && !mac_busy) begin
          state_nxt = etsc_pkg::ST_DECIDE;
        end
      end
      etsc_pkg::ST_DECIDE: begin
        if (!ov_r) begin
          ov_nxt   = 1'b1;
          oen_nxt  = mac_acc;
          ocmd_nxt = 1'b0;
          priority if (mac_acc > upper_r) begin
            amp_nxt  = (amp_r >= maxa_r) ? maxa_r : amp_r + 1'b1;
            ocmd_nxt = 1'b1;
            ost_nxt  = etsc_pkg::STIM_ABOVE;
          end else if (mac_acc < lower_r) begin
            if (amp_r != '0) begin
              amp_nxt  = amp_r - 1'b1;
              ocmd_nxt = 1'b1;
            end
            ost_nxt = etsc_pkg::STIM_BELOW;
          end else begin
            ost_nxt = etsc_pkg::STIM_BETWEEN;
          end
          state_nxt = etsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = etsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= etsc_pkg::ST_CLEAR;
      sum_r    <= '0;
      fill_r   <= '0;
      wpos_r   <= '0;
      clr_r    <= '0;
      remain_r <= '0;
      iss_v_r  <= 1'b0;
      seen_r   <= '0;
      amp_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
      fill_r   <= fill_nxt;
      wpos_r   <= wpos_nxt;
      clr_r    <= clr_nxt;
      remain_r <= remain_nxt;
      iss_v_r  <= iss_v_nxt;
      seen_r   <= seen_nxt;
      amp_r    <= amp_nxt;
      ov_r     <= ov_nxt;
    end
    mean_r <= mean_nxt;
    n_r    <= n_nxt;
    wi_r   <= wi_nxt;
    ridx_r <= ridx_nxt;
    oen_r  <= oen_nxt;
    ost_r  <= ost_nxt;
    ocmd_r <= ocmd_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.energy     = oen_r;
  assign out_ch.stim_state = ost_r;
  assign out_ch.amplitude  = amp_r;
  assign out_ch.cmd_sent   = ocmd_r;

endmodule

>>> rtl/etsc_div.sv
`timescale 1ns / 1ps
module etsc_div #(
  parameter int unsigned DW = 33,
  parameter int unsigned VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [VW:0]   trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[DW-1]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = VW'(trial - {1'b0, divisor});
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

>>> rtl/etsc_mac.sv
`timescale 1ns / 1ps
module etsc_mac #(
  parameter int unsigned DW = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          in_v,
  input  logic signed [DW-1:0]          d,
  output logic                          busy,
  output logic [etsc_pkg::ENERGY_W-1:0] acc
);

  localparam int unsigned SQW = 2 * DW;

  logic [SQW-1:0]                   sq_r;
  logic                             sq_v_r;
  logic [etsc_pkg::ENERGY_W-1:0]    acc_r, acc_nxt;
  logic [etsc_pkg::ENERGY_W:0]      sum;

  // saturating accumulate of the registered square
  always_comb begin
    sum     = (etsc_pkg::ENERGY_W + 1)'(acc_r) + (etsc_pkg::ENERGY_W + 1)'(sq_r);
    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (sq_v_r) begin
      if (sum > (etsc_pkg::ENERGY_W + 1)'(etsc_pkg::ENERGY_MAX)) begin
        acc_nxt = etsc_pkg::ENERGY_MAX;
      end else begin
        acc_nxt = sum[etsc_pkg::ENERGY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      sq_v_r <= in_v && !clr;
      acc_r  <= acc_nxt;
    end
    sq_r <= SQW'($signed(d) * $signed(d));
  end

  assign busy = sq_v_r;
  assign acc  = acc_r;

endmodule
